// ===== hdl/mkdlp_pkg.sv =====
// Shared types and constants for the multi-key debounce and long-press block.
`default_nettype none
package mkdlp_pkg;

  localparam int NUM_KEYS = 4;
  localparam int KEY_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

  localparam int PIN_W = 4;
  localparam int NOW_W = 32;
  localparam int TH_W  = 16;
  localparam int EVT_W = 4;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_LEVELS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MS     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_MS       = 2'd2;

  localparam logic [PIN_W-1:0] ACTIVE_RESET = 4'd1;
  localparam logic [TH_W-1:0]  FILTER_RESET = 16'd20;
  localparam logic [TH_W-1:0]  LONG_RESET   = 16'd1000;

  localparam logic [EVT_W-1:0] EVT_NONE = 4'd0;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_DEBOUNCE = 2'd1,
    PH_PRESSED  = 2'd2,
    PH_LONG     = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } seq_state_t;

endpackage
`default_nettype wire

// ===== hdl/multi_key_debounce_long_press.sv =====
// Top level: multi-key debounce with short and long press events.
`default_nettype none
// Each input request carries the raw pin levels of the keys and a millisecond
// timestamp; it yields exactly one result with an event code (0 none, 2i+1
// short press of key i, 2i+2 long press of key i). A request is taken in the
// idle state, then the scan state visits the keys in index order (up to
// NUM_KEYS, fewer when an event ends the scan early), then the done state
// moves the code into the output register; a previous result still stalled
// on the output holds the block in that last step. A single shared
// elapsed-time subtractor and threshold comparator serves the scan, which
// visits one key per cycle. A new request is taken while the
// previous result still waits on the output. Configuration writes are taken
// at any time with cfg_ready held high; write only while the block is idle.
module multi_key_debounce_long_press
  import mkdlp_pkg::*;
(
  input  wire                    clk,
  input  wire                    rst,
  // s_axis_tdata: [3:0] pin_levels, [35:4] now_ms, [39:36] zero
  input  wire                    s_axis_tvalid,
  output logic                   s_axis_tready,
  input  wire [IN_TDATA_W-1:0]   s_axis_tdata,
  // m_axis_tdata: [3:0] event_code, [7:4] zero
  output logic                   m_axis_tvalid,
  input  wire                    m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input  wire                    cfg_valid,
  output logic                   cfg_ready,
  input  wire [CFG_IDX_W-1:0]    cfg_index,
  input  wire [CFG_DATA_W-1:0]   cfg_data
);

  seq_state_t state, state_next;

  logic [PIN_W-1:0] active_levels;
  logic [TH_W-1:0]  filter_ms;
  logic [TH_W-1:0]  long_ms;

  phase_t           key_phase [NUM_KEYS];
  logic [NOW_W-1:0] press_start_ms [NUM_KEYS];

  logic [PIN_W-1:0] pins;
  logic [NOW_W-1:0] now;
  logic [KEY_W-1:0] key, key_next;
  logic [EVT_W-1:0] code, code_next;
  logic [EVT_W-1:0] out_code;
  logic             out_valid;

  logic [NUM_KEYS-1:0] down_vec;
  logic                down;
  phase_t              ph, ph_next;
  logic                wr_start;
  logic                ev;
  logic [7:0]          code_full;
  logic [NOW_W-1:0]    elapsed;
  logic [TH_W-1:0]     thr;
  logic                ge;
  logic                last_key;
  logic                scan_en;
  logic                load_out;

  assign cfg_ready     = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_TDATA_W-EVT_W){1'b0}}, out_code};

  // Keys past the pin field are forced to read as down.
  always_comb begin
    for (int i = 0; i < NUM_KEYS; i++) begin
      if (i < PIN_W) begin
        down_vec[i] = (pins[i] == active_levels[i]);
      end else begin
        down_vec[i] = 1'b1;
      end
    end
  end

  // Shared unit: wrapped elapsed time against the threshold of the current phase.
  assign ph       = key_phase[key];
  assign down     = down_vec[key];
  assign elapsed  = now - press_start_ms[key];
  assign thr      = (ph == PH_DEBOUNCE) ? filter_ms : long_ms;
  assign ge       = (elapsed >= {{(NOW_W-TH_W){1'b0}}, thr});
  assign last_key = (key == KEY_W'(NUM_KEYS - 1));

  always_comb begin
    ph_next   = ph;
    wr_start  = 1'b0;
    ev        = 1'b0;
    code_full = 8'd0;
    case (ph)
      PH_IDLE: begin
        if (down) begin
          ph_next  = PH_DEBOUNCE;
          wr_start = 1'b1;
        end
      end
      PH_DEBOUNCE: begin
        if (!down) begin
          ph_next = PH_IDLE;
        end else if (ge) begin
          ph_next = PH_PRESSED;
        end
      end
      PH_PRESSED: begin
        if (!down) begin
          ev        = 1'b1;
          code_full = 8'({key, 1'b0}) + 8'd1;
          ph_next   = PH_IDLE;
        end else if (ge) begin
          ev        = 1'b1;
          code_full = 8'({key, 1'b0}) + 8'd2;
          ph_next   = PH_LONG;
        end
      end
      PH_LONG: begin
        if (!down) begin
          ph_next = PH_IDLE;
        end
      end
      default: begin
        ph_next = PH_IDLE;
      end
    endcase
  end

  always_comb begin
    state_next    = state;
    key_next      = key;
    code_next     = code;
    s_axis_tready = 1'b0;
    scan_en       = 1'b0;
    load_out      = 1'b0;
    case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          key_next   = '0;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        scan_en = 1'b1;
        // The first event ends the scan; later keys keep their state.
        if (ev || last_key) begin
          code_next  = ev ? code_full[EVT_W-1:0] : EVT_NONE;
          state_next = ST_DONE;
        end else begin
          key_next = key + KEY_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid || m_axis_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_levels <= ACTIVE_RESET;
      filter_ms     <= FILTER_RESET;
      long_ms       <= LONG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ACTIVE_LEVELS: active_levels <= cfg_data[PIN_W-1:0];
        CFG_FILTER_MS:     filter_ms     <= cfg_data[TH_W-1:0];
        CFG_LONG_MS:       long_ms       <= cfg_data[TH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_KEYS; i++) begin
        key_phase[i]      <= PH_IDLE;
        press_start_ms[i] <= '0;
      end
    end else if (scan_en) begin
      key_phase[key] <= ph_next;
      if (wr_start) begin
        press_start_ms[key] <= now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      pins <= s_axis_tdata[PIN_W-1:0];
      now  <= s_axis_tdata[PIN_W+NOW_W-1:PIN_W];
    end
    if (load_out) begin
      out_code <= code;
    end
    key  <= key_next;
    code <= code_next;
  end

endmodule
`default_nettype wire

// ===== hdl/mkdlp_checker.sv =====
// Port-level checker for the debounce block and its bind to the top level.
`default_nettype none
module mkdlp_checker
  import mkdlp_pkg::*;
(
  input wire                   clk,
  input wire                   rst,
  input wire                   s_axis_tvalid,
  input wire                   s_axis_tready,
  input wire                   m_axis_tvalid,
  input wire                   m_axis_tready,
  input wire [OUT_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // Event codes never point past the last key.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[EVT_W-1:0] <= EVT_W'(2 * NUM_KEYS)
      || 2 * NUM_KEYS >= (1 << EVT_W))
    else $error("event code out of range");

  // The block scans after taking a request, so it cannot take another at once.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("request taken during scan");

  // No result appears in the cycle right after a request when none was pending.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
    else $error("result appeared before scan");

  // Pad bits of the result stay zero.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[OUT_TDATA_W-1:EVT_W] == '0)
    else $error("result pad bits set");

endmodule

bind multi_key_debounce_long_press mkdlp_checker u_mkdlp_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire

// ===== tb/tb_multi_key_debounce_long_press.sv =====
// Testbench for the multi-key debounce block: directed and random key scans checked against a predictor.
`default_nettype none
module tb_multi_key_debounce_long_press;
  import mkdlp_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int SETTLE_CYCLES = NUM_KEYS + 2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  multi_key_debounce_long_press dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor copy of the key machines and the registers
  phase_t key_ph [NUM_KEYS];
  logic [NOW_W-1:0] key_t0 [NUM_KEYS];
  logic [PIN_W-1:0] cfg_active;
  logic [TH_W-1:0] cfg_filter;
  logic [TH_W-1:0] cfg_hold;

  logic [EVT_W-1:0] pending_events[$];
  int errors = 0;
  int scans_sent = 0;
  int reg_writes = 0;
  int short_seen = 0;
  int long_seen = 0;
  int quiet_seen = 0;
  int burst_left = 0;
  int idle_cycles = 0;
  int rx_mode = 0;
  int rx_left = 0;
  int rx_tick = 0;

  function automatic void reset_keys();
    cfg_active = ACTIVE_RESET;
    cfg_filter = FILTER_RESET;
    cfg_hold   = LONG_RESET;
    for (int k = 0; k < NUM_KEYS; k++) begin
      key_ph[k] = PH_IDLE;
      key_t0[k] = '0;
    end
  endfunction

  // Walk the keys in index order; the first event ends the scan.
  function automatic logic [EVT_W-1:0] scan_keys(input logic [PIN_W-1:0] pins,
                                                 input logic [NOW_W-1:0] now);
    logic [EVT_W-1:0] code;
    logic down;
    logic [NOW_W-1:0] held;
    code = EVT_NONE;
    for (int k = 0; k < NUM_KEYS && code == EVT_NONE; k++) begin
      down = (k < PIN_W) ? (pins[k] == cfg_active[k]) : 1'b1;
      held = now - key_t0[k];
      case (key_ph[k])
        PH_IDLE: begin
          if (down) begin
            key_ph[k] = PH_DEBOUNCE;
            key_t0[k] = now;
          end
        end
        PH_DEBOUNCE: begin
          if (!down) key_ph[k] = PH_IDLE;
          else if (held >= NOW_W'(cfg_filter)) key_ph[k] = PH_PRESSED;
        end
        PH_PRESSED: begin
          if (!down) begin
            code = EVT_W'(2 * k + 1);
            key_ph[k] = PH_IDLE;
          end else if (held >= NOW_W'(cfg_hold)) begin
            code = EVT_W'(2 * k + 2);
            key_ph[k] = PH_LONG;
          end
        end
        default: begin
          if (!down) key_ph[k] = PH_IDLE;
        end
      endcase
    end
    return code;
  endfunction

  // Send one scan request; bursts of random length with random gaps between them.
  task automatic send_scan(input logic [PIN_W-1:0] pins, input logic [NOW_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 10);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {{(IN_TDATA_W - PIN_W - NOW_W){1'b0}}, now, pins};
    do @(posedge clk); while (!s_axis_tready);
    pending_events.push_back(scan_keys(pins, now));
    scans_sent++;
  endtask

  // Hold requests until every expected result is back, then let the block settle.
  task automatic drain_events();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (pending_events.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves cfg_valid high so back-to-back writes need no second assignment.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_ACTIVE_LEVELS: cfg_active = value[PIN_W-1:0];
      CFG_FILTER_MS:     cfg_filter = value[TH_W-1:0];
      CFG_LONG_MS:       cfg_hold = value[TH_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic set_config(input logic [PIN_W-1:0] lv, input logic [TH_W-1:0] f,
                            input logic [TH_W-1:0] l);
    write_reg(CFG_ACTIVE_LEVELS, CFG_DATA_W'(lv));
    write_reg(CFG_FILTER_MS, CFG_DATA_W'(f));
    write_reg(CFG_LONG_MS, CFG_DATA_W'(l));
    cfg_valid <= 1'b0;
  endtask

  // Reset settings: key 0 active high, the rest active low; released is 4'b1110.
  task automatic test_default_sequence();
    send_scan(4'b1110, 32'hFFFF_FFF0);
    send_scan(4'b1111, 32'hFFFF_FFF0);
    // confirm across the counter wrap
    send_scan(4'b1111, 32'h0000_0004);
    send_scan(4'b1110, 32'h0000_0005);
    send_scan(4'b1100, 32'd10);
    send_scan(4'b1100, 32'd40);
    send_scan(4'b1100, 32'd1040);
    send_scan(4'b1110, 32'd1042);
    // release during debounce
    send_scan(4'b1010, 32'd2000);
    send_scan(4'b1110, 32'd2005);
    // key 0 event ends the scan before key 3 sees its release
    send_scan(4'b0111, 32'd3000);
    send_scan(4'b0111, 32'd3030);
    send_scan(4'b0110, 32'd3031);
    send_scan(4'b1110, 32'd3032);
    send_scan(4'b0000, 32'd4000);
    send_scan(4'b0000, 32'd4020);
    send_scan(4'b0000, 32'd5000);
    send_scan(4'b0000, 32'd5001);
    send_scan(4'b0000, 32'd5002);
    send_scan(4'b1110, 32'd5003);
  endtask

  task automatic test_zero_times();
    drain_events();
    set_config(4'hF, 16'd0, 16'd0);
    send_scan(4'b0100, 32'd100);
    send_scan(4'b0100, 32'd100);
    send_scan(4'b0100, 32'd100);
    send_scan(4'b0000, 32'd101);
  endtask

  task automatic test_late_release();
    drain_events();
    set_config(4'hF, 16'd0, 16'hFFFF);
    send_scan(4'b0010, 32'd0);
    send_scan(4'b0010, 32'd0);
    send_scan(4'b0000, 32'h8000_0000);
  endtask

  task automatic test_unused_index();
    drain_events();
    write_reg(CFG_UNUSED, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // Mostly slow key changes so presses get confirmed, with some noisy scans and time jumps.
  task automatic test_random_scans(input int n, input logic [PIN_W-1:0] lv,
                                   input logic [TH_W-1:0] f, input logic [TH_W-1:0] l);
    logic [PIN_W-1:0] pins;
    logic [NOW_W-1:0] now;
    int unsigned span;
    drain_events();
    set_config(lv, f, l);
    span = ((f > l) ? int'(f) : int'(l)) / 3 + 1;
    pins = ~lv;
    now = $urandom;
    for (int j = 0; j < n; j++) begin
      if (j == n / 2) drain_events();
      if ($urandom_range(0, 9) == 0) pins = PIN_W'($urandom);
      else begin
        for (int k = 0; k < PIN_W; k++)
          if ($urandom_range(0, 5) == 0) pins[k] = ~pins[k];
      end
      if ($urandom_range(0, 39) == 0) now = $urandom;
      else now = now + $urandom_range(0, span);
      send_scan(pins, now);
    end
  endtask

  // Receiver: switch between stall patterns every so often
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 3);
      rx_left <= $urandom_range(30, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= rx_tick[2];
    endcase
  end

  always @(posedge clk) begin
    logic [EVT_W-1:0] want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_events.size() == 0) begin
        $error("result with no scan pending: event_code %0d", m_axis_tdata[EVT_W-1:0]);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (m_axis_tdata[EVT_W-1:0] !== want) begin
          $error("event_code: expected %0d, got %0d", want, m_axis_tdata[EVT_W-1:0]);
          errors++;
        end
        if (m_axis_tdata[OUT_TDATA_W-1:EVT_W] !== '0) begin
          $error("tdata pad: expected 0, got %0h", m_axis_tdata[OUT_TDATA_W-1:EVT_W]);
          errors++;
        end
        if (want == EVT_NONE) quiet_seen++;
        else if (want[0]) short_seen++;
        else long_seen++;
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_multi_key_debounce_long_press: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    reset_keys();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_sequence();
    test_zero_times();
    test_late_release();
    test_random_scans(150, ACTIVE_RESET, FILTER_RESET, LONG_RESET);
    test_random_scans(120, 4'h0, 16'd0, 16'd0);
    test_random_scans(120, 4'hF, 16'hFFFF, 16'hFFFF);
    test_random_scans(150, PIN_W'($urandom), 16'd5, 16'd30);
    test_random_scans(120, PIN_W'($urandom), 16'd300, 16'd100);
    test_random_scans(100, PIN_W'($urandom), TH_W'($urandom_range(0, 2000)), TH_W'($urandom));
    test_unused_index();
    test_random_scans(90, PIN_W'($urandom), TH_W'($urandom_range(0, 50)),
                      TH_W'($urandom_range(0, 400)));
    drain_events();
    if (pending_events.size() != 0) begin
      $error("%0d expected results never arrived", pending_events.size());
      errors++;
    end
    $display("run: %0d scans over ten register settings, %0d register writes",
             scans_sent, reg_writes);
    $display("run: %0d short presses, %0d long presses, %0d quiet scans",
             short_seen, long_seen, quiet_seen);
    if (errors == 0) begin
      $display("tb_multi_key_debounce_long_press: done, clean");
    end else begin
      $display("tb_multi_key_debounce_long_press: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/mkdlp_pkg.sv
hdl/multi_key_debounce_long_press.sv
hdl/mkdlp_checker.sv
tb/tb_multi_key_debounce_long_press.sv
